// ----- sv/mrwt_pkg.sv -----
// ----------------------------------------------------------------------------
// mrwt_pkg
// shared types and verdict codes for the miller-rabin witness test
// ----------------------------------------------------------------------------
package mrwt_pkg;

   localparam int CandWidth = 32;
   localparam int BaseWidth = 31;
   localparam int VerdWidth = 3;

   typedef enum logic [VerdWidth-1:0] {
      VERD_PRIME     = 3'd0,
      VERD_COMPOSITE = 3'd1,
      VERD_NONPOS    = 3'd2,
      VERD_ONE       = 3'd3,
      VERD_EVEN      = 3'd4
   } verdict_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_POW,
      ST_CHECK,
      ST_SQUARE,
      ST_DONE
   } state_type;

endpackage

// ----- sv/mrwt_front.sv -----
// ----------------------------------------------------------------------------
// mrwt_front
// pre-checks each request and queues it for the back end (two entry queue)
// ----------------------------------------------------------------------------
module mrwt_front import mrwt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [CandWidth-1:0] cand,
   input  logic [BaseWidth-1:0] base,
   output logic                 q_valid,
   input  logic                 q_take,
   output logic                 q_pre,
   output verdict_type          q_verd,
   output logic [CandWidth-1:0] q_cand,
   output logic [BaseWidth-1:0] q_base
);

   localparam int EntW = 1 + VerdWidth + CandWidth + BaseWidth;

   logic [EntW-1:0] mem_ff [2];
   logic            wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            pre;
   verdict_type     verd;
   logic            do_push;

   // classification
   always_comb begin
      pre  = 1'b1;
      verd = VERD_PRIME;
      if (cand == '0 || cand[CandWidth-1]) verd = VERD_NONPOS;
      else if (cand == CandWidth'(1)) verd = VERD_ONE;
      else if (!cand[0]) verd = VERD_EVEN;
      else pre = 1'b0;
   end

   assign full    = (cnt_ff == 2'd2);
   assign do_push = push && !full;
   assign q_valid = (cnt_ff != 2'd0);
   assign {q_pre, q_verd, q_cand, q_base} = mem_ff[rp_ff];

   // queue pointers
   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ (q_take && q_valid);
      cnt_in = cnt_ff + 2'(do_push) - 2'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wp_ff] <= {pre, verd, cand, base};
   end

endmodule

// ----- sv/mrwt_back.sv -----
// ----------------------------------------------------------------------------
// mrwt_back
// modular exponentiation and squaring sequencer with a bit-serial multiplier
// ----------------------------------------------------------------------------
module mrwt_back import mrwt_pkg::*; #(
   parameter int NUM_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_take,
   input  logic                 q_pre,
   input  verdict_type          q_verd,
   input  logic [CandWidth-1:0] q_cand,
   input  logic [BaseWidth-1:0] q_base,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output verdict_type          rsp_verd
);

   localparam int W  = NUM_WIDTH;
   localparam int BW = (BaseWidth > W) ? BaseWidth : W;
   localparam int CW = $clog2(W + 1);
   localparam int MW = (CandWidth < W) ? CandWidth : W;

   state_type st_ff, st_in;
   logic [W-1:0]  n_ff, n_in, nm1;
   logic [W-1:0]  d_ff, d_in, x_ff, x_in, b_ff, b_in;
   logic [BW-1:0] a_ff, a_in;
   logic [CW-1:0] s_ff, s_in, cnt_ff, cnt_in;
   logic [CW-1:0] bit_ff, bit_in;
   logic [1:0]    ph_ff, ph_in;
   logic [W-1:0]  acc_ff, acc_in, ml_x_ff, ml_x_in, ml_y_ff, ml_y_in;
   logic          mbusy_ff, mbusy_in;
   logic          outv_ff, outv_in;
   verdict_type   outd_ff, outd_in;
   logic [W:0]    dbl, sum;
   logic [W-1:0]  step1, step2;

   assign nm1       = n_ff - W'(1);
   assign rsp_empty = !outv_ff;
   assign rsp_verd  = outd_ff;

   // one mul step: acc = 2*acc (+x) mod n
   always_comb begin
      dbl   = {1'b0, acc_ff} + {1'b0, acc_ff};
      step1 = (dbl >= {1'b0, n_ff}) ? W'(dbl - {1'b0, n_ff}) : W'(dbl);
      sum   = {1'b0, step1} + {1'b0, ml_x_ff};
      step2 = ml_y_ff[W-1] ? ((sum >= {1'b0, n_ff}) ? W'(sum - {1'b0, n_ff}) : W'(sum))
                           : step1;
   end

   always_comb begin
      st_in = st_ff; n_in = n_ff; d_in = d_ff; x_in = x_ff; b_in = b_ff;
      a_in = a_ff; s_in = s_ff; cnt_in = cnt_ff; bit_in = bit_ff; ph_in = ph_ff;
      acc_in = acc_ff; ml_x_in = ml_x_ff; ml_y_in = ml_y_ff; mbusy_in = mbusy_ff;
      outv_in = outv_ff && !rsp_pop; outd_in = outd_ff; q_take = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid && !outv_ff) begin
               q_take = 1'b1;
               if (q_pre) begin
                  outv_in = 1'b1; outd_in = q_verd;
               end else begin
                  n_in = '0;
                  n_in[MW-1:0] = q_cand[MW-1:0];
                  a_in = BW'(q_base);
                  cnt_in = '0;
                  st_in = ST_REDUCE;
               end
            end
         end
         // a mod n, largest fitting shifted n removed per cycle; also s and d
         ST_REDUCE: begin
            if (n_ff == W'(1)) begin
               outv_in = 1'b1; outd_in = VERD_PRIME; st_in = ST_IDLE;
            end else if (a_ff >= BW'(n_ff)) begin
               a_in = a_ff - BW'(n_ff);
               for (int k = 1; k < BW; k++)
                  if ((BW'(n_ff) << k) <= a_ff && ((BW'(n_ff) << k) >> k) == BW'(n_ff))
                     a_in = a_ff - (BW'(n_ff) << k);
            end else begin
               b_in = W'(a_ff); x_in = W'(1); d_in = nm1 >> 1; s_in = CW'(1);
               // trailing zero count of n-1
               for (int k = 1; k < W; k++)
                  if ((nm1 & ~({W{1'b1}} << k)) == '0) begin
                     d_in = nm1 >> k; s_in = CW'(k);
                  end
               st_in = ST_POW; ph_in = 2'd0;
            end
         end
         // square and multiply: ph 0 pick, 1 mul r, 2 square base
         ST_POW: begin
            if (mbusy_ff) begin
               acc_in = step2; ml_y_in = ml_y_ff << 1; bit_in = bit_ff - CW'(1);
               if (bit_ff == CW'(1)) begin
                  mbusy_in = 1'b0;
                  if (ph_ff == 2'd1) begin x_in = step2; ph_in = 2'd2; end
                  else begin b_in = step2; d_in = d_ff >> 1; ph_in = 2'd0; end
               end
            end else if (ph_ff == 2'd0) begin
               if (d_ff == '0) st_in = ST_CHECK;
               else if (d_ff[0]) ph_in = 2'd1;
               else ph_in = 2'd2;
            end else begin
               mbusy_in = 1'b1; acc_in = '0; bit_in = CW'(W);
               ml_x_in = (ph_ff == 2'd1) ? x_ff : b_ff; ml_y_in = b_ff;
            end
         end
         ST_CHECK: begin
            if (x_ff == W'(1) || x_ff == nm1) begin
               outv_in = 1'b1; outd_in = VERD_PRIME; st_in = ST_DONE;
            end else if (s_ff <= CW'(1)) begin
               outv_in = 1'b1; outd_in = VERD_COMPOSITE; st_in = ST_DONE;
            end else begin
               s_in = s_ff - CW'(1); mbusy_in = 1'b1; acc_in = '0; bit_in = CW'(W);
               ml_x_in = x_ff; ml_y_in = x_ff; st_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            acc_in = step2; ml_y_in = ml_y_ff << 1; bit_in = bit_ff - CW'(1);
            if (bit_ff == CW'(1)) begin
               mbusy_in = 1'b0; x_in = step2;
               if (step2 == nm1) begin
                  outv_in = 1'b1; outd_in = VERD_PRIME; st_in = ST_DONE;
               end else if (s_ff <= CW'(1)) begin
                  outv_in = 1'b1; outd_in = VERD_COMPOSITE; st_in = ST_DONE;
               end else begin
                  s_in = s_ff - CW'(1); mbusy_in = 1'b1; acc_in = '0;
                  bit_in = CW'(W); ml_x_in = step2; ml_y_in = step2;
               end
            end
         end
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; outv_ff <= 1'b0; mbusy_ff <= 1'b0; ph_ff <= 2'd0;
      end else begin
         st_ff <= st_in; outv_ff <= outv_in; mbusy_ff <= mbusy_in; ph_ff <= ph_in;
      end
      n_ff <= n_in; d_ff <= d_in; x_ff <= x_in; b_ff <= b_in; a_ff <= a_in;
      s_ff <= s_in; cnt_ff <= cnt_in; bit_ff <= bit_in; acc_ff <= acc_in;
      ml_x_ff <= ml_x_in; ml_y_ff <= ml_y_in; outd_ff <= outd_in;
   end

endmodule

// ----- sv/miller_rabin_witness_test_top.sv -----
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_top
// one miller-rabin round per request: candidate and base in, verdict out
// ----------------------------------------------------------------------------
// usage:
//   request side is a queue: drive req_candidate and req_witness_base, raise
//   req_push while req_full is low; each such beat is one request.
//   response side is a queue: while rsp_empty is low rsp_verdict holds the
//   oldest verdict; rsp_pop takes it.
//   pre-checked candidates (nonpositive, one, even) skip the multiplier; the
//   back end copies their verdict into the response register when idle.
//   odd candidates run the bit-serial modular multiplier, up to about
//   2*NUM_WIDTH products plus the base reduction.
//   a two entry request queue lets the host push while a test runs.
//   synchronous reset empties both queues and idles the sequencer.
//   while the response is not popped the sequencer holds and the request
//   queue fills, then req_full rises.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test_top import mrwt_pkg::*; #(
   parameter int NUM_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic signed [31:0]   req_candidate,
   input  logic [30:0]          req_witness_base,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [2:0]           rsp_verdict
);

   logic                 q_valid, q_take, q_pre;
   verdict_type          q_verd, verd;
   logic [CandWidth-1:0] q_cand;
   logic [BaseWidth-1:0] q_base;

   // front: pre-check and queue
   mrwt_front u_front (
      .clock, .reset, .push(req_push), .full(req_full),
      .cand(req_candidate), .base(req_witness_base),
      .q_valid, .q_take, .q_pre, .q_verd, .q_cand, .q_base
   );

   // back: modular arithmetic
   mrwt_back #(.NUM_WIDTH(NUM_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_pre, .q_verd, .q_cand, .q_base,
      .rsp_empty, .rsp_pop, .rsp_verd(verd)
   );

   assign rsp_verdict = verd;

endmodule

// ----- sv/mrwt_checker.sv -----
// ----------------------------------------------------------------------------
// mrwt_checker
// port level checks on the witness test block
// ----------------------------------------------------------------------------
module mrwt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [2:0] rsp_verdict
);

   a_verd_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_verdict <= 3'd4) else $error("bad verdict");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_verdict)))
      else $error("response dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full)) else $error("not empty after reset");

   a_full_src: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push)) else $error("full without push");

endmodule

bind miller_rabin_witness_test_top mrwt_checker u_mrwt_checker (
   .clock, .reset, .req_push, .req_full, .rsp_empty, .rsp_pop, .rsp_verdict
);
